// ===== design/sprite_rle_decoder_defines.svh =====
// Assertion helpers shared by the decoder files.
`ifndef SPRITE_RLE_DECODER_DEFINES_SVH
`define SPRITE_RLE_DECODER_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define SRD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/srd_pkg.sv =====
package srd_pkg;

  localparam int unsigned SizeW  = 13;  // block_width / block_height registers
  localparam int unsigned CoordW = 12;  // pixel_x / pixel_y
  localparam int unsigned CodeW  = 8;
  localparam int unsigned LitW   = 7;

  localparam logic [CodeW-1:0] EndOfRow  = 8'h80;
  localparam logic [SizeW-1:0] MaxSize   = 13'd4096;
  localparam logic [SizeW-1:0] ResetSize = 13'd256;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // Clamped block geometry as the decoder sees it.
  typedef struct packed {
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
  } geom_t;

  typedef struct packed {
    logic [CodeW-1:0] code_byte;
    logic             block_start;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [CodeW-1:0]  pixel_value;
    logic              is_pixel;
    logic              saw_transparency;
    logic              overrun_seen;
  } result_t;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) begin
      r = 13'd1;
    end else if (v > MaxSize) begin
      r = MaxSize;
    end
    return r;
  endfunction

endpackage

// ===== design/sprite_rle_decoder.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    code_byte_i, block_start_i
// out       output     out_valid_o / out_stall_i  pixel_x/y, pixel_value, is_pixel, flags
// cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One compressed byte per cycle while in_stall_o is low; a byte is taken into the input
// register, then decoded into the output register, whose result is valid on the outputs.
// The decode between those two registers is combinational.
// Reset: empty pipeline, width and height 256, decoder idle until a block start.
// A stall on the output holds the result; the input stalls only while both the
// input and output registers are occupied and the output is stalled.
module sprite_rle_decoder
  import srd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // compressed byte stream
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CodeW-1:0]  code_byte_i,
  input  logic              block_start_i,
  // pixel writes and end-of-block markers
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic [CodeW-1:0]  pixel_value_o,
  output logic              is_pixel_o,
  output logic              saw_transparency_o,
  output logic              overrun_seen_o,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [SizeW-1:0]  cfg_data_i
);

  logic [SizeW-1:0] width_q;
  logic [SizeW-1:0] height_q;
  geom_t            geom;
  in_item_t         in_item;
  in_item_t         held_item;
  logic             held_full;
  logic             out_ready;
  logic             advance;
  logic             emit;
  result_t          dec_res;
  result_t          out_res;

  // Geometry registers; a write applies to the next byte decoded, also in mid-block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetSize;
      height_q <= ResetSize;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Out-of-range sizes act as the nearest legal one (1..4096).
  assign geom.width  = clamp_size(width_q);
  assign geom.height = clamp_size(height_q);

  assign in_item.code_byte   = code_byte_i;
  assign in_item.block_start = block_start_i;

  // The held byte is decoded whenever the output register can take a result,
  // even if this byte produces none.
  assign advance = held_full && out_ready;

  srd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .item_i    (in_item),
    .advance_i (advance),
    .full_o    (held_full),
    .item_o    (held_item)
  );

  srd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .geom_i   (geom),
    .item_i   (held_item),
    .advance_i(advance),
    .emit_o   (emit),
    .res_o    (dec_res)
  );

  srd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (emit),
    .res_i      (dec_res),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (out_res)
  );

  assign pixel_x_o          = out_res.pixel_x;
  assign pixel_y_o          = out_res.pixel_y;
  assign pixel_value_o      = out_res.pixel_value;
  assign is_pixel_o         = out_res.is_pixel;
  assign saw_transparency_o = out_res.saw_transparency;
  assign overrun_seen_o     = out_res.overrun_seen;

endmodule

// ===== design/srd_in_reg.sv =====
module srd_in_reg
  import srd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t item_i,
  input  logic     advance_i,
  output logic     full_o,
  output in_item_t item_o
);

  logic     full_q, full_d;
  in_item_t item_q;
  logic     load;

  // Take a new item when empty or when the held one moves on this cycle.
  assign in_stall_o = full_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign full_d     = load || (full_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign full_o = full_q;
  assign item_o = item_q;

endmodule

// ===== design/srd_decode.sv =====
`include "sprite_rle_decoder_defines.svh"

module srd_decode
  import srd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  geom_t    geom_i,
  input  in_item_t item_i,
  input  logic     advance_i,
  output logic     emit_o,
  output result_t  res_o
);

  logic [CoordW-1:0] row_q, row_d;
  logic [SizeW-1:0]  col_q, col_d;
  logic [LitW-1:0]   lit_q, lit_d;
  logic              fin_q, fin_d;
  logic              trans_q, trans_d;
  logic              ovr_q, ovr_d;

  logic [SizeW-1:0]  height_m1;
  logic [SizeW-1:0]  skip_n;
  logic [SizeW-1:0]  room;
  logic              as_code;
  logic              emit;
  logic              is_pix;
  logic [CoordW-1:0] px_x;
  logic [CoordW-1:0] px_y;
  logic [CodeW-1:0]  px_val;

  assign height_m1 = geom_i.height - 13'd1;

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    lit_d   = lit_q;
    fin_d   = fin_q;
    trans_d = trans_q;
    ovr_d   = ovr_q;
    emit    = 1'b0;
    is_pix  = 1'b0;
    px_x    = '0;
    px_y    = '0;
    px_val  = '0;
    as_code = 1'b1;
    skip_n  = '0;
    room    = '0;

    if (item_i.block_start) begin
      row_d   = height_m1[CoordW-1:0];
      col_d   = '0;
      lit_d   = '0;
      fin_d   = 1'b0;
      trans_d = 1'b0;
      ovr_d   = 1'b0;
    end

    if (fin_d) begin
      as_code = 1'b0;
    end else if (lit_d != '0) begin
      if (col_d < geom_i.width) begin
        // literal byte: one pixel at the current column
        px_x    = col_d[CoordW-1:0];
        px_y    = row_d;
        px_val  = item_i.code_byte;
        is_pix  = 1'b1;
        emit    = 1'b1;
        as_code = 1'b0;
        col_d   = col_d + 13'd1;
        lit_d   = lit_d - 7'd1;
        if (lit_d != '0 && col_d >= geom_i.width) begin
          ovr_d = 1'b1;
          lit_d = '0;
        end
      end else begin
        ovr_d = 1'b1;
        lit_d = '0;
      end
    end

    if (as_code) begin
      if (item_i.code_byte == EndOfRow) begin
        if (col_d < geom_i.width) begin
          trans_d = 1'b1;
        end
        if (row_d == '0) begin
          fin_d = 1'b1;
          col_d = '0;
          emit  = 1'b1;
        end else begin
          row_d = row_d - 12'd1;
          col_d = '0;
        end
      end else if (item_i.code_byte > EndOfRow) begin
        skip_n = {6'd0, item_i.code_byte[LitW-1:0]};
        room   = (col_d < geom_i.width) ? (geom_i.width - col_d) : '0;
        if (skip_n > room) begin
          skip_n = room;
          ovr_d  = 1'b1;
        end
        col_d   = col_d + skip_n;
        trans_d = 1'b1;
      end else if (item_i.code_byte != '0) begin
        if (col_d >= geom_i.width) begin
          ovr_d = 1'b1;
        end else begin
          lit_d = item_i.code_byte[LitW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      lit_q   <= '0;
      fin_q   <= 1'b1;
      trans_q <= 1'b0;
      ovr_q   <= 1'b0;
    end else if (advance_i) begin
      row_q   <= row_d;
      col_q   <= col_d;
      lit_q   <= lit_d;
      fin_q   <= fin_d;
      trans_q <= trans_d;
      ovr_q   <= ovr_d;
    end
  end

  assign emit_o                 = advance_i && emit;
  assign res_o.pixel_x          = px_x;
  assign res_o.pixel_y          = px_y;
  assign res_o.pixel_value      = px_val;
  assign res_o.is_pixel         = is_pix;
  assign res_o.saw_transparency = trans_d;
  assign res_o.overrun_seen     = ovr_d;

  `SRD_ASSERT(a_col_bound, clk_i, rst_ni, col_q <= MaxSize, "column count past max size")
  `SRD_ASSERT(a_lit_live, clk_i, rst_ni, (lit_q != '0) |-> !fin_q, "literal run while idle")
  `SRD_ASSERT(a_eob_fin, clk_i, rst_ni, (emit_o && !res_o.is_pixel) |=> fin_q, "end of block not idle")
  `SRD_ASSERT(a_idle_quiet, clk_i, rst_ni, (fin_q && !item_i.block_start) |-> !emit, "result while idle")

endmodule

// ===== design/srd_out_reg.sv =====
`include "sprite_rle_decoder_defines.svh"

module srd_out_reg
  import srd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    full_q, full_d;
  result_t res_q;

  assign ready_o = !full_q || !out_stall_i;
  assign full_d  = push_i || (full_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = full_q;
  assign res_o       = res_q;

  `SRD_ASSERT(a_no_overwrite, clk_i, rst_ni, push_i |-> ready_o, "push into a held result")
  `SRD_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_o || rst_ni, "valid out of reset")

endmodule
